// ===== hw/rtl/scr128_pkg.sv =====
// ----------------------------------------------------------------------------
// scr128_pkg
// Shared constants and round functions for the 128-bit block scrambler.
// ----------------------------------------------------------------------------
package scr128_pkg;

    localparam int ROUNDS     = 32;
    localparam int STAGES     = 2 * ROUNDS;
    localparam int WORD_W     = 64;
    localparam int KEY_WORDS  = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [WORD_W-1:0] DELTA = 64'h9e37_79b9_7f4a_7c15;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] IDX_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_KEY3 = 3'd3;

    typedef logic [WORD_W-1:0] word_t;

    // running sum after round r (counted from 0), wraps modulo 2^64
    function automatic word_t round_sum(input int r);
        logic [2*WORD_W-1:0] prod;
        prod = 128'(DELTA) * 128'(r + 1);
        return prod[WORD_W-1:0];
    endfunction

    // half round feeding v0: built from v1 with keys 0 and 1
    function automatic word_t mix_low(input word_t w, input word_t s,
                                      input word_t ka, input word_t kb);
        return ((w << 7) + ka) ^ (w + s) ^ ((w >> 12) + kb);
    endfunction

    // half round feeding v1: built from v0 with keys 2 and 3
    function automatic word_t mix_high(input word_t w, input word_t s,
                                       input word_t ka, input word_t kb);
        return ((w << 16) + ka) ^ (w + s) ^ ((w >> 8) + kb);
    endfunction

endpackage

// ===== hw/rtl/tea_style_block_scramble_128_top.sv =====
// ----------------------------------------------------------------------------
// tea_style_block_scramble_128_top
// Pipelined 32-round Feistel scrambler of 128-bit blocks under a 256-bit key.
// ----------------------------------------------------------------------------
// One block enters per cycle while s_tready is high: every half round (one
// 64-bit word update) owns a register stage, giving 2 * ROUNDS stages. Each
// stage holds its item while the next one is full and stalled, and bubbles
// close up, so requests keep flowing into empty stages while a finished
// result waits at the output. The user must write key words through the
// configuration port only while the pipeline is empty; it is not enforced.
module tea_style_block_scramble_128_top
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [scr128_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scr128_pkg::WORD_W-1:0]    cfg_data,
    // input blocks
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] block_low, [127:64] block_high
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] result_low, [127:64] result_high
);

    localparam int STAGES = scr128_pkg::STAGES;

    scr128_pkg::word_t key_reg [scr128_pkg::KEY_WORDS];

    scr128_pkg::word_t v0_reg [STAGES];
    scr128_pkg::word_t v1_reg [STAGES];
    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   ready;

    // ------------------------------------------------------------------
    // key registers; writes beyond the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scr128_pkg::KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                scr128_pkg::IDX_KEY0: key_reg[0] <= cfg_data;
                scr128_pkg::IDX_KEY1: key_reg[1] <= cfg_data;
                scr128_pkg::IDX_KEY2: key_reg[2] <= cfg_data;
                scr128_pkg::IDX_KEY3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage flow control: a stage loads when empty or when it empties
    // ------------------------------------------------------------------
    assign ready[STAGES] = m_tready;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            localparam int RND = k / 2;
            localparam scr128_pkg::word_t SUM = scr128_pkg::round_sum(RND);

            logic              in_valid;
            scr128_pkg::word_t in_v0;
            scr128_pkg::word_t in_v1;
            scr128_pkg::word_t v0_next;
            scr128_pkg::word_t v1_next;

            assign ready[k] = !valid_reg[k] || ready[k+1];

            if (k == 0)
            begin : g_first
                assign in_valid = s_tvalid;
                assign in_v0    = s_tdata[63:0];
                assign in_v1    = s_tdata[127:64];
            end
            else
            begin : g_chain
                assign in_valid = valid_reg[k-1];
                assign in_v0    = v0_reg[k-1];
                assign in_v1    = v1_reg[k-1];
            end

            if ((k % 2) == 0)
            begin : g_low
                assign v0_next = in_v0 + scr128_pkg::mix_low(in_v1, SUM,
                                                             key_reg[0], key_reg[1]);
                assign v1_next = in_v1;
            end
            else
            begin : g_high
                assign v0_next = in_v0;
                assign v1_next = in_v1 + scr128_pkg::mix_high(in_v0, SUM,
                                                              key_reg[2], key_reg[3]);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ready[k])
                begin
                    valid_reg[k] <= in_valid;
                end
            end

            // payload: advance only with a valid item
            always_ff @(posedge clk)
            begin
                if (ready[k] && in_valid)
                begin
                    v0_reg[k] <= v0_next;
                    v1_reg[k] <= v1_next;
                end
            end
        end
    endgenerate

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {v1_reg[STAGES-1], v0_reg[STAGES-1]};

endmodule

// ===== hw/rtl/scr128_checker.sv =====
// ----------------------------------------------------------------------------
// scr128_checker
// Port-level checks on the scrambler: request accounting and output hold.
// ----------------------------------------------------------------------------
module scr128_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    localparam int CNT_W = $clog2(scr128_pkg::STAGES + 2);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             take_in;
    logic             take_out;

    assign take_in  = s_tvalid && s_tready;
    assign take_out = m_tvalid && m_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (take_in && !take_out)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (!take_in && take_out)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result without an accepted request
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != '0)
        else $error("result without pending request");

    // pipeline never holds more than one item per stage
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(scr128_pkg::STAGES))
        else $error("more requests in flight than stages");

    // an empty pipeline always takes a request
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> s_tready)
        else $error("empty pipeline refused a request");

endmodule

bind tea_style_block_scramble_128_top scr128_checker u_scr128_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/scr128_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scr128_scoreboard
// Watches the scrambler's channels, predicts each result and compares.
// ----------------------------------------------------------------------------
// Tracks key writes, runs its own 32-round Feistel computation for every
// accepted request, and matches results in order against the oldest
// prediction. Mismatches and unexpected results are counted for the top.
module scr128_scoreboard
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [scr128_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scr128_pkg::WORD_W-1:0]        cfg_data,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [127:0]                         s_tdata,   // [63:0] block_low, [127:64] block_high
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [127:0]                         m_tdata,   // [63:0] result_low, [127:64] result_high
    output int                                   errors,
    output int                                   pending
);

    localparam int SHL_V1 = 7;
    localparam int SHR_V1 = 12;
    localparam int SHL_V0 = 16;
    localparam int SHR_V0 = 8;

    typedef struct packed {
        scr128_pkg::word_t high;
        scr128_pkg::word_t low;
    } block_t;

    scr128_pkg::word_t keys [scr128_pkg::KEY_WORDS];
    block_t            expected_blocks [$];

    function automatic block_t scramble_block(input block_t blk);
        scr128_pkg::word_t a;
        scr128_pkg::word_t b;
        scr128_pkg::word_t s;
        block_t res;
        a = blk.low;
        b = blk.high;
        s = '0;
        for (int r = 0; r < scr128_pkg::ROUNDS; r++)
        begin
            s = s + scr128_pkg::DELTA;
            a = a + ((((b << SHL_V1) + keys[0]) ^ (b + s) ^ ((b >> SHR_V1) + keys[1])));
            b = b + ((((a << SHL_V0) + keys[2]) ^ (a + s) ^ ((a >> SHR_V0) + keys[3])));
        end
        res.low  = a;
        res.high = b;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input scr128_pkg::word_t got,
                                   input scr128_pkg::word_t want);
        $display("[%0t] mismatch: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        block_t want;
        block_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < scr128_pkg::KEY_WORDS; i++)
            begin
                keys[i] = '0;
            end
            expected_blocks.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // writes beyond the key words are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    scr128_pkg::IDX_KEY0: keys[0] = cfg_data;
                    scr128_pkg::IDX_KEY1: keys[1] = cfg_data;
                    scr128_pkg::IDX_KEY2: keys[2] = cfg_data;
                    scr128_pkg::IDX_KEY3: keys[3] = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_blocks.size() == 0)
                begin
                    report_mismatch("result with no request pending", got.low, '0);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (got.low !== want.low)
                    begin
                        report_mismatch("result_low", got.low, want.low);
                    end
                    if (got.high !== want.high)
                    begin
                        report_mismatch("result_high", got.high, want.high);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_blocks.push_back(scramble_block(s_tdata));
            end
            pending = expected_blocks.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 128-bit block scrambler.
// ----------------------------------------------------------------------------
// Drives directed corner blocks and about 600 random blocks under several
// key settings (zero, all ones, alternating extremes, random), pokes the
// unused register indexes, and varies idling on both sides including two long
// output holds that back the pipeline up. Checking lives in scr128_scoreboard;
// this module only counts blocks and key settings and reports the outcome.
module tb_top;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BLOCKS  = 100;
    localparam scr128_pkg::word_t ONES = '1;
    localparam scr128_pkg::word_t ZERO = '0;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [scr128_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [scr128_pkg::WORD_W-1:0]        cfg_data;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [127:0]                         s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [127:0]                         m_tdata;

    int errors;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;
    int blocks_sent;
    int key_settings;

    wire progress = (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we;

    tea_style_block_scramble_128_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    scr128_scoreboard u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic scr128_pkg::word_t rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            return ZERO;
        end
        if (pick < 16)
        begin
            return ONES;
        end
        return {$urandom, $urandom};
    endfunction

    // offer one request, holding it until accepted
    task automatic send_block(input scr128_pkg::word_t low, input scr128_pkg::word_t high);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {high, low};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        blocks_sent++;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    // write all key words; optionally scribble on the unused indexes too
    task automatic program_keys(input scr128_pkg::word_t k0, input scr128_pkg::word_t k1,
                                input scr128_pkg::word_t k2, input scr128_pkg::word_t k3,
                                input bit poke_unused);
        scr128_pkg::word_t k [scr128_pkg::KEY_WORDS];
        k = '{k0, k1, k2, k3};
        for (int i = 0; i < scr128_pkg::KEY_WORDS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= scr128_pkg::CFG_IDX_W'(i);
            cfg_data  <= k[i];
            @(posedge clk);
        end
        if (poke_unused)
        begin
            for (int i = scr128_pkg::KEY_WORDS; i < 2 ** scr128_pkg::CFG_IDX_W; i++)
            begin
                cfg_we    <= 1'b1;
                cfg_index <= scr128_pkg::CFG_IDX_W'(i);
                cfg_data  <= {$urandom, $urandom};
                @(posedge clk);
            end
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        key_settings++;
    endtask

    task automatic send_corner_blocks();
        send_block(ZERO, ZERO);
        send_block(ONES, ONES);
        send_block(ZERO, ONES);
        send_block(ONES, ZERO);
        send_block(64'h8000_0000_0000_0000, 64'h1);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    task automatic send_random_blocks(input int count, input bit with_hold);
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == count / 3)
            begin
                hold_request = 1'b1;
            end
            send_block(rand_word(), rand_word());
        end
    endtask

    // receiver: random backpressure plus one long hold on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        m_tready  <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
                m_tready    <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || progress)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        hold_request = 1'b0;
        blocks_sent  = 0;
        key_settings = 1;
        tx_idle_pct  = 31;
        rx_idle_pct  = 47;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keys at their reset value
        send_corner_blocks();
        drain_pipeline();

        program_keys(ONES, ONES, ONES, ONES, 1'b0);
        send_corner_blocks();
        drain_pipeline();

        // unused indexes must leave the keys alone
        program_keys(ONES, ZERO, ONES, ZERO, 1'b1);
        send_corner_blocks();
        drain_pipeline();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    tx_idle_pct = 31;
                    rx_idle_pct = 47;
                end
                1:
                begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 31;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 3)
            begin
                program_keys(ZERO, ONES, ZERO, ONES, 1'b1);
            end
            else
            begin
                program_keys(rand_word(), rand_word(), rand_word(), rand_word(),
                             ($urandom_range(1) == 1));
            end
            send_random_blocks(PHASE_BLOCKS, (phase == 0 || phase == 4));
            drain_pipeline();
        end

        repeat (2 * scr128_pkg::STAGES + 8) @(posedge clk);
        $display("Covered %0d blocks under %0d key settings, unused index writes,",
                 blocks_sent, key_settings);
        $display("three idle mixes and long output holds; %0d mismatches, %0d left over.",
                 errors, pending);
        if (errors == 0 && pending == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
